[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared constants for the text console writer
// Screen geometry, field widths, character codes and register map.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    // Item field widths
    localparam int CODE_W  = 8;
    localparam int STYLE_W = 8;
    localparam int IDX_W   = 11;
    localparam int CELL_W  = CODE_W + STYLE_W;

    localparam logic [CELL_W-1:0]  RESET_CELL      = 16'h0F20;
    localparam logic [STYLE_W-1:0] BLANK_STYLE_RST = 8'h0F;

    localparam logic [CODE_W-1:0] CODE_NUL   = 8'h00;
    localparam logic [CODE_W-1:0] CODE_TAB   = 8'h09;
    localparam logic [CODE_W-1:0] CODE_NL    = 8'h0A;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'h20;

    localparam int TAB_SPACES = 4;
    localparam int LEFT_W     = $clog2(TAB_SPACES + 1);

    // Configuration port
    localparam int REG_COUNT       = 1;
    localparam int PADDR_W         = $clog2(4 * REG_COUNT);
    localparam int PDATA_W         = 32;
    localparam int REG_BLANK_STYLE = 0;

endpackage

[rtl/tcw_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_in_if / tcw_out_if: item channels of the text console writer
// Valid/ready handshake with the input and result payload fields.
// ----------------------------------------------------------------------------
interface tcw_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [tcw_pkg::CODE_W-1:0]   char_code;
    logic [tcw_pkg::STYLE_W-1:0]  cell_style;
    logic [tcw_pkg::IDX_W-1:0]    read_index;

    modport source (output valid, mode, char_code, cell_style, read_index, input ready);
    modport sink   (input valid, mode, char_code, cell_style, read_index, output ready);
endinterface

interface tcw_out_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::IDX_W-1:0]    cursor_position;
    logic [tcw_pkg::CELL_W-1:0]   cell_value;

    modport source (output valid, cursor_position, cell_value, input ready);
    modport sink   (input valid, cursor_position, cell_value, output ready);
endinterface

[rtl/tcw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tcw_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cfg: configuration register block
// APB-style access to the blank style register.
// ----------------------------------------------------------------------------
module tcw_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [tcw_pkg::STYLE_W-1:0]  o_blank_style
);

    logic [tcw_pkg::STYLE_W-1:0] r_blank_style;
    logic                        sel_blank;

    // Word index is the byte address over four
    assign sel_blank = ((paddr >> 2) == tcw_pkg::PADDR_W'(tcw_pkg::REG_BLANK_STYLE));
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_style <= tcw_pkg::BLANK_STYLE_RST;
        end else if (psel && penable && pwrite && pready && sel_blank) begin
            r_blank_style <= pwdata[tcw_pkg::STYLE_W-1:0];
        end
    end

    assign prdata = sel_blank ?
        {{(tcw_pkg::PDATA_W - tcw_pkg::STYLE_W){1'b0}}, r_blank_style} : '0;
    assign o_blank_style = r_blank_style;

endmodule

[rtl/tcw_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_seq: console sequencer
// Cursor tracking and a cell-at-a-time walk over the screen RAM for clear,
// character store, scroll copy and bottom-row blanking.
// ----------------------------------------------------------------------------
module tcw_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tcw_in_if.sink                       i_in,
    tcw_out_if.source                    o_out,
    input  logic [tcw_pkg::STYLE_W-1:0]  i_blank_style,
    output logic                         o_ram_we,
    output logic [tcw_pkg::ADDR_W-1:0]   o_ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0]   o_ram_wdata,
    output logic [tcw_pkg::ADDR_W-1:0]   o_ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]   i_ram_rdata
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_READ    = 3'd2;
    localparam logic [2:0] S_PUT     = 3'd3;
    localparam logic [2:0] S_NEWLINE = 3'd4;
    localparam logic [2:0] S_SCROLL  = 3'd5;
    localparam logic [2:0] S_BLANK   = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    localparam int AW = tcw_pkg::ADDR_W;
    localparam logic [AW-1:0] A_COLS      = AW'(tcw_pkg::COLUMNS);
    localparam logic [AW-1:0] A_LAST      = AW'(tcw_pkg::CELL_COUNT - 1);
    localparam logic [AW-1:0] A_LAST_COPY = AW'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS - 1);
    localparam logic [AW-1:0] A_BOTTOM    = AW'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);

    logic [2:0]                      r_state, n_state;
    logic [AW-1:0]                   r_addr, n_addr;
    logic [AW-1:0]                   r_wr_addr, n_wr_addr;
    logic                            r_wr_pend, n_wr_pend;
    logic [tcw_pkg::ROW_W-1:0]       r_row, n_row;
    logic [tcw_pkg::COL_W-1:0]       r_col, n_col;
    logic [AW-1:0]                   r_base, n_base;
    logic [tcw_pkg::LEFT_W-1:0]      r_left, n_left;
    logic [tcw_pkg::CODE_W-1:0]      r_code, n_code;
    logic [tcw_pkg::STYLE_W-1:0]     r_style, n_style;
    logic                            r_in_range, n_in_range;
    logic [tcw_pkg::CELL_W-1:0]      r_val, n_val;
    logic                            r_out_valid, n_out_valid;
    logic [tcw_pkg::IDX_W-1:0]       r_out_pos, n_out_pos;
    logic [tcw_pkg::CELL_W-1:0]      r_out_val, n_out_val;
    logic [AW-1:0]                   pos;

    assign pos = r_base + AW'(r_col);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_wr_addr   = r_wr_addr;
        n_wr_pend   = r_wr_pend;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_left      = r_left;
        n_code      = r_code;
        n_style     = r_style;
        n_in_range  = r_in_range;
        n_val       = r_val;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_pos   = r_out_pos;
        n_out_val   = r_out_val;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_addr;
        o_ram_wdata = tcw_pkg::RESET_CELL;
        o_ram_raddr = r_addr + A_COLS;

        case (r_state)
            S_CLEAR: begin
                o_ram_we = 1'b1;
                if (r_addr == A_LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                o_ram_raddr = AW'(i_in.read_index);
                if (i_in.valid) begin
                    n_code     = i_in.char_code;
                    n_style    = i_in.cell_style;
                    n_in_range = (i_in.read_index < tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT));
                    n_val      = '0;
                    if (i_in.mode) begin
                        n_state = S_READ;
                    end else begin
                        case (i_in.char_code)
                            tcw_pkg::CODE_NUL: begin
                                n_state = S_DONE;
                            end
                            tcw_pkg::CODE_NL: begin
                                n_left  = '0;
                                n_state = S_NEWLINE;
                            end
                            tcw_pkg::CODE_TAB: begin
                                n_code  = tcw_pkg::CODE_SPACE;
                                n_left  = tcw_pkg::LEFT_W'(tcw_pkg::TAB_SPACES);
                                n_state = S_PUT;
                            end
                            default: begin
                                n_left  = tcw_pkg::LEFT_W'(1);
                                n_state = S_PUT;
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                n_val   = r_in_range ? i_ram_rdata : '0;
                n_state = S_DONE;
            end
            S_PUT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = pos;
                o_ram_wdata = {r_style, r_code};
                n_left      = r_left - tcw_pkg::LEFT_W'(1);
                if (r_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
                    n_state = S_NEWLINE;
                end else begin
                    n_col   = r_col + tcw_pkg::COL_W'(1);
                    n_state = (r_left == tcw_pkg::LEFT_W'(1)) ? S_DONE : S_PUT;
                end
            end
            S_NEWLINE: begin
                if (r_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                    n_addr    = A_COLS;
                    n_wr_pend = 1'b0;
                    n_state   = S_SCROLL;
                end else begin
                    n_row   = r_row + tcw_pkg::ROW_W'(1);
                    n_base  = r_base + A_COLS;
                    n_col   = '0;
                    n_state = (r_left != '0) ? S_PUT : S_DONE;
                end
            end
            S_SCROLL: begin
                // Read one row below, write it back in the following cycle
                n_wr_addr = r_addr;
                n_wr_pend = 1'b1;
                if (r_wr_pend) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_wr_addr;
                    o_ram_wdata = i_ram_rdata;
                end
                if (r_addr == A_LAST_COPY) begin
                    n_addr  = A_BOTTOM;
                    n_state = S_BLANK;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_BLANK: begin
                o_ram_we = 1'b1;
                if (r_wr_pend) begin
                    // Drain the last copied cell first
                    o_ram_waddr = r_wr_addr;
                    o_ram_wdata = i_ram_rdata;
                    n_wr_pend   = 1'b0;
                end else begin
                    o_ram_wdata = {i_blank_style, tcw_pkg::CODE_SPACE};
                    if (r_addr == A_LAST) begin
                        n_col   = '0;
                        n_state = (r_left != '0) ? S_PUT : S_DONE;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = tcw_pkg::IDX_W'(pos);
                    n_out_val   = r_val;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_wr_pend   <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_wr_pend   <= n_wr_pend;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_code     <= n_code;
        r_style    <= n_style;
        r_in_range <= n_in_range;
        r_val      <= n_val;
        r_out_pos  <= n_out_pos;
        r_out_val  <= n_out_val;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.cursor_position = r_out_pos;
    assign o_out.cell_value      = r_out_val;

endmodule

[rtl/text_console_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: character console with scrolling cell store
// Takes character items, keeps a ROWS x COLUMNS screen and a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per handshake: a character with its style byte, or
//   a read of one screen cell. o_out returns one item per input item with the
//   cursor position and, for reads, the cell value.
//   A scroll copies rows 2 and up one row up, leaving row 0 in place, then
//   blanks the bottom row with the configured blank style, one cell per
//   cycle.
//   One item is in work at a time; i_in.ready is high only when idle.
//   A finished item sits in the output register; the next input item is
//   taken while it waits, but the following one completes only after the
//   receiver takes it.
//   After reset the screen is cleared to style 0x0F spaces, one cell per
//   cycle, with i_in.ready low until all CELL_COUNT cells are written.
//   Configuration writes are taken at any time, including during the clear.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tcw_in_if.sink                       i_in,
    tcw_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    logic [tcw_pkg::STYLE_W-1:0] blank_style;
    logic                        ram_we;
    logic [tcw_pkg::ADDR_W-1:0]  ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    logic [tcw_pkg::ADDR_W-1:0]  ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

    tcw_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_blank_style (blank_style)
    );

    tcw_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_blank_style (blank_style),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

[tb/text_console_writer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// Feeds character and cell-read items with random gaps on both channels,
// predicts cursor position and cell contents with a software screen copy,
// and changes the scroll blank style over the APB port between phases.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam int STALL_LIMIT = 12000;  // reset clear + scroll + long sink hold, several times
    localparam int LONG_HOLD   = 800;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic                        mode;
        logic [tcw_pkg::CODE_W-1:0]  char_code;
        logic [tcw_pkg::STYLE_W-1:0] cell_style;
        logic [tcw_pkg::IDX_W-1:0]   read_index;
    } t_console_item;

    typedef struct packed {
        logic [tcw_pkg::IDX_W-1:0]  cursor_position;
        logic [tcw_pkg::CELL_W-1:0] cell_value;
    } t_console_result;

    logic                        i_clk;
    logic                        i_rst_n = 1'b0;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [tcw_pkg::PADDR_W-1:0] paddr   = '0;
    logic [tcw_pkg::PDATA_W-1:0] pwdata  = '0;
    logic [tcw_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    logic          feed_valid = 1'b0;
    t_console_item feed_item  = '0;
    logic          sink_ready = 1'b0;

    tcw_in_if  in_ch ();
    tcw_out_if out_ch ();

    assign in_ch.valid      = feed_valid;
    assign in_ch.mode       = feed_item.mode;
    assign in_ch.char_code  = feed_item.char_code;
    assign in_ch.cell_style = feed_item.cell_style;
    assign in_ch.read_index = feed_item.read_index;
    assign out_ch.ready     = sink_ready;

    text_console_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Screen copy and cursor
    logic [tcw_pkg::CELL_W-1:0]  screen_copy [tcw_pkg::CELL_COUNT];
    int unsigned                 cursor_col;
    int unsigned                 cursor_row;
    logic [tcw_pkg::STYLE_W-1:0] blank_style;

    t_console_item   console_items_q[$];
    t_console_result console_results_q[$];

    int          error_count   = 0;
    int          results_seen  = 0;
    int          idle_cycles   = 0;
    bit          in_fire       = 1'b0;
    int unsigned send_gap      = 0;
    int unsigned send_tick     = 0;
    bit          send_calm     = 1'b0;
    int unsigned sink_hold     = 0;
    int unsigned sink_tick     = 0;
    bit          sink_calm     = 1'b0;
    bit          long_hold_done = 1'b0;

    function automatic void line_feed();
        if (cursor_row >= tcw_pkg::ROWS - 1) begin
            // row 0 is a fixed banner: shift rows 2.. up into 1..
            for (int r = 2; r < tcw_pkg::ROWS; r++) begin
                for (int c = 0; c < tcw_pkg::COLUMNS; c++) begin
                    screen_copy[(r - 1) * tcw_pkg::COLUMNS + c] =
                        screen_copy[r * tcw_pkg::COLUMNS + c];
                end
            end
            for (int c = 0; c < tcw_pkg::COLUMNS; c++) begin
                screen_copy[(tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS + c] =
                    {blank_style, tcw_pkg::CODE_SPACE};
            end
            cursor_row = tcw_pkg::ROWS - 1;
            cursor_col = 0;
        end else begin
            cursor_col = 0;
            cursor_row++;
        end
    endfunction

    function automatic void put_glyph(input logic [tcw_pkg::CODE_W-1:0] code,
                                      input logic [tcw_pkg::STYLE_W-1:0] style);
        screen_copy[cursor_row * tcw_pkg::COLUMNS + cursor_col] = {style, code};
        if (cursor_col >= tcw_pkg::COLUMNS - 1) begin
            line_feed();
        end else begin
            cursor_col++;
        end
    endfunction

    function automatic t_console_result next_console_result(input t_console_item item);
        t_console_result res;
        res = '0;
        if (item.mode == MODE_READ) begin
            if (item.read_index < tcw_pkg::CELL_COUNT) begin
                res.cell_value = screen_copy[item.read_index];
            end
        end else if (item.char_code == tcw_pkg::CODE_NUL) begin
            // dropped
        end else if (item.char_code == tcw_pkg::CODE_NL) begin
            line_feed();
        end else if (item.char_code == tcw_pkg::CODE_TAB) begin
            repeat (tcw_pkg::TAB_SPACES) put_glyph(tcw_pkg::CODE_SPACE, item.cell_style);
        end else begin
            put_glyph(item.char_code, item.cell_style);
        end
        res.cursor_position = tcw_pkg::IDX_W'(cursor_row * tcw_pkg::COLUMNS + cursor_col);
        return res;
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(10, 60);
        end
    endfunction

    function automatic void push_item(input logic mode,
                                      input logic [tcw_pkg::CODE_W-1:0] code,
                                      input logic [tcw_pkg::STYLE_W-1:0] style,
                                      input logic [tcw_pkg::IDX_W-1:0] idx);
        t_console_item item;
        item.mode       = mode;
        item.char_code  = code;
        item.cell_style = style;
        item.read_index = idx;
        console_items_q.push_back(item);
    endfunction

    // Mostly printable text, with newlines, tabs, dropped codes and reads mixed in
    function automatic t_console_item random_item();
        t_console_item item;
        int unsigned   r;
        r               = $urandom_range(0, 99);
        item.mode       = MODE_WRITE;
        item.char_code  = tcw_pkg::CODE_W'($urandom_range(0, 255));
        item.cell_style = tcw_pkg::STYLE_W'($urandom_range(0, 255));
        item.read_index = tcw_pkg::IDX_W'($urandom_range(0, 2047));
        if (r < 16) begin
            item.mode = MODE_READ;
            // aim a share of reads at the banner and the rows touched by scrolling
            case ($urandom_range(0, 2))
                0: item.read_index = tcw_pkg::IDX_W'($urandom_range(0, 3 * tcw_pkg::COLUMNS - 1));
                1: item.read_index = tcw_pkg::IDX_W'(
                       $urandom_range((tcw_pkg::ROWS - 2) * tcw_pkg::COLUMNS, 2047));
                default: ;
            endcase
        end else if (r < 22) begin
            item.char_code = tcw_pkg::CODE_NL;
        end else if (r < 27) begin
            item.char_code = tcw_pkg::CODE_TAB;
        end else if (r < 30) begin
            item.char_code = tcw_pkg::CODE_NUL;
        end
        return item;
    endfunction

    function automatic void fill_random(input int count);
        t_console_item item;
        int            taken;
        taken = 0;
        while (taken < count) begin
            item = random_item();
            console_items_q.push_back(item);
            if (item.mode == MODE_READ || item.char_code != tcw_pkg::CODE_NUL) begin
                taken++;
            end
        end
    endfunction

    task automatic wait_drained();
        while (console_items_q.size() != 0 || console_results_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic apb_access(input logic write, input logic [tcw_pkg::PDATA_W-1:0] wdata,
                              output logic [tcw_pkg::PDATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= tcw_pkg::PADDR_W'(4 * tcw_pkg::REG_BLANK_STYLE);
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_blank_style(input logic [tcw_pkg::STYLE_W-1:0] style);
        logic [tcw_pkg::PDATA_W-1:0] rdata;
        apb_access(1'b1, tcw_pkg::PDATA_W'(style), rdata);
        blank_style = style;
        apb_access(1'b0, '0, rdata);
        if (rdata !== tcw_pkg::PDATA_W'(style)) begin
            $error("blank_style readback: expected 0x%0h, got 0x%0h", style, rdata);
            error_count++;
        end
    endtask

    // Sender: hold an offered item until taken, then idle for its gap
    always @(negedge i_clk) begin
        send_tick++;
        if (send_tick % 256 == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
        end
        if (!i_rst_n) begin
            feed_valid <= 1'b0;
        end else if (feed_valid && !in_fire) begin
            // hold
        end else if (send_gap > 0) begin
            feed_valid <= 1'b0;
            send_gap   <= send_gap - 1;
        end else if (console_items_q.size() != 0) begin
            feed_valid <= 1'b1;
            feed_item  <= console_items_q[0];
            send_gap   <= pick_gap(send_calm);
        end else begin
            feed_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(negedge i_clk) begin : sink_drive
        int unsigned gap;
        sink_tick++;
        if (sink_tick % 256 == 128) begin
            sink_calm = ($urandom_range(0, 3) == 0);
        end
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_ready <= 1'b0;
            sink_hold  <= sink_hold - 1;
        end else if (!long_hold_done && results_seen >= 150) begin
            long_hold_done <= 1'b1;
            sink_ready     <= 1'b0;
            sink_hold      <= LONG_HOLD - 1;
        end else begin
            gap = pick_gap(sink_calm);
            if (gap > 0) begin
                sink_ready <= 1'b0;
                sink_hold  <= gap - 1;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_console_item   item;
        t_console_result want;
        bit              moved;
        in_fire = 1'b0;
        moved   = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid === 1'b1 && sink_ready) begin
                moved = 1'b1;
                results_seen++;
                if (console_results_q.size() == 0) begin
                    $error("unexpected result item: cursor_position %0d, cell_value 0x%0h",
                           out_ch.cursor_position, out_ch.cell_value);
                    error_count++;
                end else begin
                    want = console_results_q.pop_front();
                    if (out_ch.cursor_position !== want.cursor_position) begin
                        $error("cursor_position: expected %0d, got %0d",
                               want.cursor_position, out_ch.cursor_position);
                        error_count++;
                    end
                    if (out_ch.cell_value !== want.cell_value) begin
                        $error("cell_value: expected 0x%04h, got 0x%04h",
                               want.cell_value, out_ch.cell_value);
                        error_count++;
                    end
                end
            end
            if (feed_valid && in_ch.ready === 1'b1) begin
                moved   = 1'b1;
                in_fire = 1'b1;
                item.mode       = in_ch.mode;
                item.char_code  = in_ch.char_code;
                item.cell_style = in_ch.cell_style;
                item.read_index = in_ch.read_index;
                void'(console_items_q.pop_front());
                console_results_q.push_back(next_console_result(item));
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("text_console_writer_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) begin
            screen_copy[i] = tcw_pkg::RESET_CELL;
        end
        cursor_col  = 0;
        cursor_row  = 0;
        blank_style = tcw_pkg::BLANK_STYLE_RST;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_blank_style(8'h00);

        // Reads of untouched cells, including past the end of the screen
        push_item(MODE_READ, 8'hFF, 8'hFF, 11'd0);
        push_item(MODE_READ, 8'h00, 8'h00, tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT - 1));
        push_item(MODE_READ, 8'h41, 8'h12, tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT));
        push_item(MODE_READ, 8'h0A, 8'hFF, 11'h7FF);
        // Dropped code with a busy read_index
        push_item(MODE_WRITE, tcw_pkg::CODE_NUL, 8'hFF, 11'h7FF);
        push_item(MODE_WRITE, 8'h41, 8'h00, 11'h7FF);
        push_item(MODE_WRITE, 8'hFF, 8'hFF, 11'h000);
        push_item(MODE_WRITE, 8'h01, 8'h80, 11'h555);
        push_item(MODE_WRITE, 8'h80, 8'h7F, 11'h2AA);
        push_item(MODE_WRITE, tcw_pkg::CODE_TAB, 8'hAA, 11'd0);
        push_item(MODE_WRITE, 8'h0B, 8'h55, 11'd0);
        push_item(MODE_WRITE, 8'h08, 8'h01, 11'd0);
        push_item(MODE_WRITE, tcw_pkg::CODE_NL, 8'h33, 11'd0);
        push_item(MODE_WRITE, 8'h0D, 8'hFE, 11'd0);
        push_item(MODE_WRITE, 8'h1B, 8'h7E, 11'd0);
        for (int i = 0; i < 9; i++) begin
            push_item(MODE_READ, 8'h00, 8'h00, tcw_pkg::IDX_W'(i));
        end
        push_item(MODE_READ, 8'h00, 8'h00, tcw_pkg::IDX_W'(tcw_pkg::COLUMNS + 1));
        fill_random(300);
        wait_drained();

        set_blank_style(8'hFF);
        fill_random(330);
        wait_drained();

        set_blank_style(tcw_pkg::STYLE_W'($urandom_range(1, 254)));
        fill_random(330);
        wait_drained();

        set_blank_style(8'h0F);
        fill_random(320);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("text_console_writer_tb: done, clean");
        end else begin
            $display("text_console_writer_tb: done, errors");
        end
        $finish;
    end

endmodule
